@@ rtl/lprd_pkg.sv @@
// Shared constants and types for the length-prefixed record deframer.
// No dependencies; used by the channel interfaces and the top level.
package lprd_pkg;

    localparam int HEAD_LINE_MAX_DEF = 19;
    localparam int COUNT_BITS_DEF    = 26;

    localparam int CFG_W   = 26;
    localparam int LEN_W   = 27;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;

    localparam logic [CFG_W-1:0] CFG_MAX_RESET = CFG_W'(32 * 1024 * 1024);
    localparam logic [LEN_W-1:0] LEN_SAT       = {LEN_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_BODY        = 3'd0;
    localparam t_kind K_EMPTY       = 3'd1;
    localparam t_kind K_END         = 3'd2;
    localparam t_kind K_BAD_HEAD    = 3'd3;
    localparam t_kind K_HEAD_LONG   = 3'd4;
    localparam t_kind K_BAD_TERM    = 3'd5;
    localparam t_kind K_TOO_LONG    = 3'd6;
    localparam t_kind K_UNSUPPORTED = 3'd7;

endpackage

@@ rtl/lprd_byte_if.sv @@
// Input channel: one stream word (byte) per handshake, valid/ready.
// Depends on lprd_pkg for the byte width.
interface lprd_byte_if;
    logic                         valid;
    logic                         ready;
    logic [lprd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/lprd_rec_if.sv @@
// Output channel: one result word per handshake (kind, payload, record_last).
// Depends on lprd_pkg for the kind type and byte width.
interface lprd_rec_if;
    logic                         valid;
    logic                         ready;
    lprd_pkg::t_kind              kind;
    logic [lprd_pkg::BYTE_W-1:0]  payload;
    logic                         record_last;

    modport source (output valid, output kind, output payload, output record_last,
                    input ready);
    modport sink   (input valid, input kind, input payload, input record_last,
                    output ready);
endinterface

@@ rtl/length_prefixed_record_deframer.sv @@
// Length-prefixed record deframer: takes one stream byte per word on i_byte and
// splits it into packets of records (decimal length line, body, LF or CR LF).
// Throughput is one byte per clock while o_rec takes each result word; a stall on
// o_rec holds the input. Every byte passes an input register and then a result
// register, which takes its result word once it is free to load. The
// per-byte parse is a single pass of shallow logic
// (a x10 shift-add for the length digits and one 27-bit count compare) between
// those two registers. Each byte gives at most one result word: a body byte,
// an empty-record or packet-end event, or an error. Errors are sticky until
// reset: after one, bytes are still taken but nothing more comes out.
// i_cfg_wr_en/i_cfg_wr_data write max_packet_bytes; write it only while idle.
// There is no memory and no clearing pass after reset.
module length_prefixed_record_deframer #(
    parameter int HEAD_LINE_MAX = lprd_pkg::HEAD_LINE_MAX_DEF,
    parameter int COUNT_BITS    = lprd_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lprd_pkg::CFG_W-1:0]  i_cfg_wr_data,
    lprd_byte_if.sink                   i_byte,
    lprd_rec_if.source                  o_rec
);

    // line byte counter only needs to reach HEAD_LINE_MAX-1
    localparam int LINE_W = (HEAD_LINE_MAX > 2) ? $clog2(HEAD_LINE_MAX) : 1;
    localparam int PKT_W  = COUNT_BITS + 1;
    localparam int CMP_W  = (PKT_W > lprd_pkg::CFG_W) ? PKT_W : lprd_pkg::CFG_W;
    localparam int SUM_W  = lprd_pkg::LEN_W + 4;

    localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(HEAD_LINE_MAX - 1);

    // parser phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_HEAD    = 3'd1;
    localparam logic [2:0] PH_BODY    = 3'd2;
    localparam logic [2:0] PH_TERM    = 3'd3;
    localparam logic [2:0] PH_TERM_CR = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // configuration
    logic [lprd_pkg::CFG_W-1:0]   r_max;

    // input register
    logic                         r_in_valid;
    logic [lprd_pkg::BYTE_W-1:0]  r_in_byte;

    // parser state
    logic [2:0]                   r_phase,    n_phase;
    logic [LINE_W-1:0]            r_line,     n_line;
    logic [lprd_pkg::LEN_W-1:0]   r_len,      n_len;
    logic                         r_dig_open, n_dig_open;
    logic                         r_began_cr, n_began_cr;
    logic [COUNT_BITS-1:0]        r_body_rem, n_body_rem;
    logic [PKT_W-1:0]             r_pkt,      n_pkt;

    // result register
    logic                         r_out_valid;
    lprd_pkg::t_kind              r_out_kind;
    logic [lprd_pkg::BYTE_W-1:0]  r_out_payload;
    logic                         r_out_last;

    logic                         n_emit;
    lprd_pkg::t_kind              n_kind;
    logic [lprd_pkg::BYTE_W-1:0]  n_payload;
    logic                         n_last;

    logic                         out_free;
    logic                         fire;

    // byte decode
    logic                         b_lf, b_cr, b_star, b_digit;
    logic [lprd_pkg::LEN_W-1:0]   digit_val;
    logic [SUM_W-1:0]             len_sum;
    logic [lprd_pkg::LEN_W-1:0]   len_acc;
    logic [PKT_W-1:0]             pkt_inc;
    logic                         pkt_over;
    logic [COUNT_BITS-1:0]        body_dec;

    assign out_free      = !r_out_valid || o_rec.ready;
    assign fire          = r_in_valid && out_free;
    assign i_byte.ready  = !r_in_valid || fire;

    assign o_rec.valid       = r_out_valid;
    assign o_rec.kind        = r_out_kind;
    assign o_rec.payload     = r_out_payload;
    assign o_rec.record_last = r_out_last;

    assign b_lf    = (r_in_byte == lprd_pkg::CH_LF);
    assign b_cr    = (r_in_byte == lprd_pkg::CH_CR);
    assign b_star  = (r_in_byte == lprd_pkg::CH_STAR);
    assign b_digit = (r_in_byte >= lprd_pkg::CH_0) && (r_in_byte <= lprd_pkg::CH_9);
    assign digit_val = lprd_pkg::LEN_W'(r_in_byte[3:0]);

    // length*10 + digit, saturating
    assign len_sum = (SUM_W'(r_len) << 3) + (SUM_W'(r_len) << 1) + SUM_W'(digit_val);
    assign len_acc = (len_sum > SUM_W'(lprd_pkg::LEN_SAT)) ? lprd_pkg::LEN_SAT
                                                          : len_sum[lprd_pkg::LEN_W-1:0];

    // packet byte count, saturating; includes this byte
    assign pkt_inc  = (r_pkt == {PKT_W{1'b1}}) ? r_pkt : r_pkt + PKT_W'(1);
    assign pkt_over = (CMP_W'(pkt_inc) > CMP_W'(r_max));
    assign body_dec = (r_body_rem != '0) ? r_body_rem - COUNT_BITS'(1) : r_body_rem;

    always_comb begin
        n_phase    = r_phase;
        n_line     = r_line;
        n_len      = r_len;
        n_dig_open = r_dig_open;
        n_began_cr = r_began_cr;
        n_body_rem = r_body_rem;
        n_pkt      = pkt_inc;
        n_emit     = 1'b0;
        n_kind     = lprd_pkg::K_BODY;
        n_payload  = '0;
        n_last     = 1'b0;

        case (r_phase)
            PH_START: begin
                if (b_lf || b_cr) begin
                    // blank at packet start: skipped
                end else if (b_star && (r_pkt == '0)) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_kind  = lprd_pkg::K_UNSUPPORTED;
                end else if (b_digit) begin
                    n_phase    = PH_HEAD;
                    n_line     = LINE_W'(1);
                    n_len      = digit_val;
                    n_dig_open = 1'b1;
                    n_began_cr = 1'b0;
                end else begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_kind  = lprd_pkg::K_BAD_HEAD;
                end
            end
            PH_HEAD: begin
                if (r_line == '0) begin
                    // first byte of a line after a record
                    if (b_lf) begin
                        n_phase = PH_START;
                        n_pkt   = '0;
                        n_len   = '0;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_END;
                    end else if (b_cr) begin
                        n_began_cr = 1'b1;
                        n_line     = LINE_W'(1);
                    end else if (b_digit) begin
                        n_len  = digit_val;
                        n_line = LINE_W'(1);
                    end else begin
                        n_phase = PH_ERROR;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_BAD_HEAD;
                    end
                end else if (r_began_cr) begin
                    if (b_lf && (r_line == LINE_W'(1))) begin
                        n_phase    = PH_START;
                        n_pkt      = '0;
                        n_line     = '0;
                        n_len      = '0;
                        n_dig_open = 1'b1;
                        n_began_cr = 1'b0;
                        n_emit     = 1'b1;
                        n_kind     = lprd_pkg::K_END;
                    end else begin
                        n_phase = PH_ERROR;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_BAD_HEAD;
                    end
                end else if (b_lf) begin
                    if (r_len > lprd_pkg::LEN_W'(r_max)) begin
                        n_phase = PH_ERROR;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_TOO_LONG;
                    end else if (r_len == '0) begin
                        n_phase = PH_TERM;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_EMPTY;
                    end else begin
                        n_phase    = PH_BODY;
                        n_body_rem = COUNT_BITS'(r_len);
                    end
                end else if (r_line >= LINE_LIMIT) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_kind  = lprd_pkg::K_HEAD_LONG;
                end else begin
                    n_line = r_line + LINE_W'(1);
                    // only the leading digit run counts toward the length
                    if (r_dig_open && b_digit) begin
                        n_len = len_acc;
                    end else begin
                        n_dig_open = 1'b0;
                    end
                end
            end
            PH_BODY: begin
                n_body_rem = body_dec;
                n_emit     = 1'b1;
                n_kind     = lprd_pkg::K_BODY;
                n_payload  = r_in_byte;
                if (body_dec == '0) begin
                    n_phase = PH_TERM;
                    n_last  = 1'b1;
                end
            end
            PH_TERM, PH_TERM_CR: begin
                if (b_lf) begin
                    if (pkt_over) begin
                        n_phase = PH_ERROR;
                        n_emit  = 1'b1;
                        n_kind  = lprd_pkg::K_TOO_LONG;
                    end else begin
                        // next length line
                        n_phase    = PH_HEAD;
                        n_line     = '0;
                        n_len      = '0;
                        n_dig_open = 1'b1;
                        n_began_cr = 1'b0;
                    end
                end else if (b_cr && (r_phase == PH_TERM)) begin
                    n_phase = PH_TERM_CR;
                end else begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_kind  = lprd_pkg::K_BAD_TERM;
                end
            end
            PH_ERROR: begin
                // sticky: swallow everything
                n_pkt = r_pkt;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= lprd_pkg::CFG_MAX_RESET;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_line     <= '0;
            r_len      <= '0;
            r_dig_open <= 1'b1;
            r_began_cr <= 1'b0;
            r_body_rem <= '0;
            r_pkt      <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_line     <= n_line;
            r_len      <= n_len;
            r_dig_open <= n_dig_open;
            r_began_cr <= n_began_cr;
            r_body_rem <= n_body_rem;
            r_pkt      <= n_pkt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_emit;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_emit) begin
            r_out_kind    <= n_kind;
            r_out_payload <= n_payload;
            r_out_last    <= n_last;
        end
    end

    // errors are sticky
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("parser left the error phase before reset");

    // an error result always parks the parser
    a_error_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_emit && (n_kind >= lprd_pkg::K_BAD_HEAD)) |=> (r_phase == PH_ERROR))
        else $error("error reported without entering the error phase");

    // record_last and payload only ride on body bytes
    a_last_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind != lprd_pkg::K_BODY))
            |-> (!r_out_last && (r_out_payload == '0)))
        else $error("event word carries body payload or last flag");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rec.ready) |=> (r_out_valid && $stable(r_out_kind)))
        else $error("stalled result word changed");

endmodule
